FILE: hw/rtl/c3x3_pkg.sv
package c3x3_pkg;

  // Frame limits
  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 1024;
  localparam int COEF_FRAC_BITS = 12;

  // Field widths
  localparam int DIM_W      = 11;                  // frame size registers and row counter
  localparam int COL_W      = $clog2(MAX_WIDTH);   // column counter / line buffer address
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = CH_W * NUM_CH;
  localparam int COEF_W     = 16;
  localparam int COEF_ROW_W = 3 * COEF_W;
  localparam int CFG_IDX_W  = 3;

  // Accumulator widths: 9-bit signed pixel times 16-bit weight, then two levels of 3-way adds
  localparam int PROD_W = CH_W + 1 + COEF_W;
  localparam int CSUM_W = PROD_W + 2;
  localparam int SUM_W  = CSUM_W + 2;

  // Default kernel: {1,2,1},{2,4,2},{1,2,1} / 16, left weight in the low bits
  localparam logic [COEF_W-1:0] W_ONE  = COEF_W'(1 << (COEF_FRAC_BITS - 4));
  localparam logic [COEF_W-1:0] W_TWO  = COEF_W'(2 << (COEF_FRAC_BITS - 4));
  localparam logic [COEF_W-1:0] W_FOUR = COEF_W'(4 << (COEF_FRAC_BITS - 4));
  localparam logic [COEF_ROW_W-1:0] COEF_TOP_RST = {W_ONE, W_TWO, W_ONE};
  localparam logic [COEF_ROW_W-1:0] COEF_MID_RST = {W_TWO, W_FOUR, W_TWO};
  localparam logic [COEF_ROW_W-1:0] COEF_BOT_RST = {W_ONE, W_TWO, W_ONE};

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(MAX_HEIGHT);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_COLOR_MODE,
    REG_COEF_TOP,
    REG_COEF_MID,
    REG_COEF_BOT
  } cfg_reg_e;

  typedef logic        [PIX_W-1:0]  pix_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [CSUM_W-1:0] csum_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Per-output control that rides along the filter pipeline
  typedef struct packed {
    logic valid;
    logic eof;
    logic zero_top;
    logic zero_bot;
    logic zero_left;
    logic zero_right;
  } tag_t;

  // Stage after the line buffer read
  typedef struct packed {
    logic valid;      // a word was accepted: the window shifts
    tag_t tag;        // its output, if any
    logic top_en;
    logic mid_en;
    logic fwd;        // top tap comes from the pending line buffer write
    pix_t bot;
  } rd_stage_t;

endpackage

FILE: hw/rtl/c3x3_ram.sv
module c3x3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and a write to the same address return the old entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/c3x3_cell.sv
module c3x3_cell import c3x3_pkg::*; (
  input  logic       clk,
  input  logic       shift,
  input  logic       step,
  input  pix_t       pix_in [3],
  output pix_t       pix_out [3],
  input  coef_t      wt [3],
  input  logic [2:0] zero_row,
  input  logic       zero_col,
  output csum_t      col_sum [NUM_CH]
);

  // One window column (top, mid, bottom), its products and its column sum
  pix_t  win [3];
  prod_t prod [3][NUM_CH];
  prod_t prod_next [3][NUM_CH];
  logic signed [CH_W:0] tap [3][NUM_CH];

  // Window column shifts toward the older neighbor
  always_ff @(posedge clk) begin
    if (shift) begin
      win <= pix_in;
    end
  end

  assign pix_out = win;

  // Edge taps read as zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < NUM_CH; k++) begin
        tap[i][k] = (zero_row[i] || zero_col) ? '0 : {1'b0, win[i][CH_W*k +: CH_W]};
        prod_next[i][k] = prod_t'(tap[i][k]) * prod_t'(wt[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      prod <= prod_next;
    end
  end

  // Column sum per channel
  always_ff @(posedge clk) begin
    if (step) begin
      for (int k = 0; k < NUM_CH; k++) begin
        col_sum[k] <= CSUM_W'(prod[0][k]) + CSUM_W'(prod[1][k]) + CSUM_W'(prod[2][k]);
      end
    end
  end

endmodule

FILE: hw/rtl/conv3x3_pixel_filter.sv
// Channel  | Dir | Words               | Fields (low bit up)
// ---------+-----+---------------------+-----------------------------------------
// s_*      | in  | one pixel per word  | tdata: sample0, sample1, sample2; tuser: req_type
// m_*      | out | one result per word | tdata: out0, out1, out2; tlast: end_of_frame
// cfg_*    | in  | register write      | cfg_index selects, cfg_data is the value
//
// Sustained rate is one word per clock on both sides while m_tready stays high; a word
// passes through the line buffer read, the window shift, the multiply and the two add
// levels to m_*. The result for pixel (row, col) leaves after the word at
// (row+1, col+1) is taken, or for the last column after the word at (row+2, 0), so
// frame_width+1 drain words flush the last row of a frame. Reset clears counters,
// pipeline valids and the registers to defaults; line buffers keep their contents.
// s_tready drops only while the skid stage behind the output register is full.
module conv3x3_pixel_filter import c3x3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIX_W-1:0]      s_tdata,     // sample0, sample1, sample2
  input  logic                  s_tuser,     // req_type
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [PIX_W-1:0]      m_tdata,     // out0, out1, out2
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_ROW_W-1:0] cfg_data
);

  // Configuration registers
  logic [DIM_W-1:0]      frame_width;
  logic [DIM_W-1:0]      frame_height;
  logic                  color_mode;
  logic [COEF_ROW_W-1:0] coef_row [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RST;
      frame_height <= HEIGHT_RST;
      color_mode   <= 1'b0;
      coef_row[0]  <= COEF_TOP_RST;
      coef_row[1]  <= COEF_MID_RST;
      coef_row[2]  <= COEF_BOT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        REG_COLOR_MODE:   color_mode   <= cfg_data[0];
        REG_COEF_TOP:     coef_row[0]  <= cfg_data;
        REG_COEF_MID:     coef_row[1]  <= cfg_data;
        REG_COEF_BOT:     coef_row[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame size clamped to 1..max
  logic [DIM_W-1:0] w_eff, h_eff;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (frame_width > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (frame_height > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  // Pipeline advance: everything moves unless the skid stage is occupied
  logic adv, accept, k_valid;

  assign adv      = ~k_valid;
  assign s_tready = adv;
  assign accept   = s_tvalid & adv;

  // Input position and output decision
  logic [COL_W-1:0] col, col_next;
  logic [DIM_W-1:0] row, row_next;
  logic [DIM_W:0]   col_inc, row_inc;
  logic [DIM_W-1:0] orow, ocol;
  logic             emit_a, emit_b, emit;
  tag_t             tag0;

  always_comb begin
    col_inc = (DIM_W+1)'(col) + 1'b1;
    row_inc = (DIM_W+1)'(row) + 1'b1;
    // first column closes the row two above, other columns the row above
    emit_a = (col == '0) && (row >= DIM_W'(2)) && ((row - DIM_W'(2)) < h_eff);
    emit_b = (col != '0) && (row != '0) && ((row - DIM_W'(1)) < h_eff);
    emit   = emit_a || emit_b;
    orow   = emit_a ? row - DIM_W'(2) : row - DIM_W'(1);
    ocol   = emit_a ? w_eff - DIM_W'(1) : DIM_W'(col) - DIM_W'(1);
    tag0.valid      = accept && emit;
    tag0.zero_top   = (orow == '0);
    tag0.zero_bot   = ((DIM_W+1)'(orow) + 1'b1) >= (DIM_W+1)'(h_eff);
    tag0.zero_left  = (ocol == '0);
    tag0.zero_right = ((DIM_W+1)'(ocol) + 1'b1) >= (DIM_W+1)'(w_eff);
    tag0.eof        = tag0.zero_bot && tag0.zero_right;
  end

  // Row counter runs up to frame_height+1 (the flush row), then wraps
  always_comb begin
    col_next = col;
    row_next = row;
    if (emit && tag0.eof) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= (DIM_W+1)'(w_eff)) begin
      col_next = '0;
      row_next = (row_inc > (DIM_W+1)'(h_eff) + 1'b1) ? '0 : row_inc[DIM_W-1:0];
    end else begin
      col_next = col_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Line buffers: the lower one is written at accept, the upper one one word later
  pix_t             a_rd, b_rd, b_wdata, fwd_data;
  logic             pend, last_mid_en;
  logic [COL_W-1:0] last_col;

  assign b_wdata = last_mid_en ? a_rd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_col    <= col;
      last_mid_en <= (row != '0);
      fwd_data    <= b_wdata;
    end
  end

  c3x3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_above (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (s_tuser ? '0 : s_tdata),
    .re    (accept),
    .raddr (col),
    .rdata (a_rd)
  );

  c3x3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_two_above (
    .clk   (clk),
    .we    (accept && pend),
    .waddr (last_col),
    .wdata (b_wdata),
    .re    (accept),
    .raddr (col),
    .rdata (b_rd)
  );

  // Read stage register
  rd_stage_t s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (adv) begin
      s1.valid  <= accept;
      s1.tag    <= tag0;
      s1.top_en <= (row >= DIM_W'(2));
      s1.mid_en <= (row != '0);
      s1.fwd    <= pend && (col == last_col);
      s1.bot    <= s_tuser ? '0 : s_tdata;
    end
  end

  // New window column: top, mid, bottom
  pix_t col_new [3];

  always_comb begin
    col_new[0] = s1.top_en ? (s1.fwd ? fwd_data : b_rd) : '0;
    col_new[1] = s1.mid_en ? a_rd : '0;
    col_new[2] = s1.bot;
  end

  // Tags for window, product and column-sum stages
  tag_t tag2, tag3, tag4;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2 <= '0;
      tag3 <= '0;
      tag4 <= '0;
    end else if (adv) begin
      tag2 <= s1.valid ? s1.tag : '0;
      tag3 <= tag2;
      tag4 <= tag3;
    end
  end

  // Chain of three window column cells, newest on the right; the new column enters slot 3
  pix_t  chain [4][3];
  coef_t wt_col [3][3];
  csum_t csum [3][NUM_CH];

  assign chain[3] = col_new;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        wt_col[k][i] = coef_t'(coef_row[i][COEF_W*k +: COEF_W]);
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_cell
    c3x3_cell u_cell (
      .clk      (clk),
      .shift    (adv && s1.valid),
      .step     (adv),
      .pix_in   (chain[k + 1]),
      .pix_out  (chain[k]),
      .wt       (wt_col[k]),
      .zero_row ({tag2.zero_bot, 1'b0, tag2.zero_top}),
      .zero_col ((k == 0) ? tag2.zero_left : ((k == 2) ? tag2.zero_right : 1'b0)),
      .col_sum  (csum[k])
    );
  end

  // Final sum, fraction dropped, saturated to a byte
  sum_t             total [NUM_CH];
  logic [CH_W-1:0]  res_ch [NUM_CH];
  logic [PIX_W-1:0] res_data;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      total[c] = SUM_W'(csum[0][c]) + SUM_W'(csum[1][c]) + SUM_W'(csum[2][c]);
      if (total[c][SUM_W-1]) begin
        res_ch[c] = '0;
      end else if (|total[c][SUM_W-2:COEF_FRAC_BITS+CH_W]) begin
        res_ch[c] = '1;
      end else begin
        res_ch[c] = total[c][COEF_FRAC_BITS +: CH_W];
      end
    end
    res_data = {(color_mode ? res_ch[2] : CH_W'(0)), (color_mode ? res_ch[1] : CH_W'(0)),
                res_ch[0]};
  end

  // Output register plus one skid word
  logic             in_v, o_valid, o_last, k_last;
  logic [PIX_W-1:0] o_data, k_data;

  assign in_v = adv && tag4.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      k_valid <= 1'b0;
    end else if (o_valid && !m_tready) begin
      if (in_v) begin
        k_valid <= 1'b1;
      end
    end else if (k_valid) begin
      o_valid <= 1'b1;
      k_valid <= 1'b0;
    end else begin
      o_valid <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (o_valid && !m_tready) begin
      if (in_v) begin
        k_data <= res_data;
        k_last <= tag4.eof;
      end
    end else if (k_valid) begin
      o_data <= k_data;
      o_last <= k_last;
    end else if (in_v) begin
      o_data <= res_data;
      o_last <= tag4.eof;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_data;
  assign m_tlast  = o_last;

endmodule

FILE: hw/rtl/c3x3_checker.sv
module c3x3_checker import c3x3_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [PIX_W-1:0]      m_tdata,
  input logic                  m_tlast,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [COEF_ROW_W-1:0] cfg_data
);

  // Mirror of the color mode register, seen from the write port
  logic rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb <= 1'b0;
    end else if (cfg_we && (cfg_index == REG_COLOR_MODE)) begin
      rgb <= cfg_data[0];
    end
  end

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // Input is held off only while a result waits on the output
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no pending output");

  // Input stall starts only after an output stall
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

  // Grey mode leaves out1 and out2 at zero
  a_grey_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !rgb |-> m_tdata[PIX_W-1:CH_W] == '0)
    else $error("nonzero color channel in grey mode");

endmodule

bind conv3x3_pixel_filter c3x3_checker u_checker (.*);

FILE: sim/tb.sv
module tb;
  import c3x3_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  // 3x3 window of pixels, [row 0 top][col 2 newest]
  typedef pix_t [2:0] tap_row_t;
  typedef tap_row_t [2:0] tap_grid_t;

  typedef struct packed {
    logic [CH_W-1:0] out0;
    logic [CH_W-1:0] out1;
    logic [CH_W-1:0] out2;
    logic            eof;
  } filt_result_t;

  typedef struct {
    cfg_reg_e              idx;
    logic [COEF_ROW_W-1:0] value;
  } reg_write_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata;    // sample0, sample1, sample2
  logic                  s_tuser;    // req_type
  logic                  m_tvalid;
  logic                  m_tready;
  logic [PIX_W-1:0]      m_tdata;    // out0, out1, out2
  logic                  m_tlast;    // end_of_frame
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [COEF_ROW_W-1:0] cfg_data;

  // Shadow registers and filter state of the predictor
  logic [DIM_W-1:0]      sh_width;
  logic [DIM_W-1:0]      sh_height;
  logic                  sh_rgb;
  logic [COEF_ROW_W-1:0] sh_coef [3];
  pix_t                  row_prev  [MAX_WIDTH];
  pix_t                  row_prev2 [MAX_WIDTH];
  tap_grid_t             win_px;
  int unsigned           pos_col;
  int unsigned           pos_row;

  filt_result_t pending_results[$];
  reg_write_t   reg_writes[$];

  bit tx_burst;
  bit rx_burst;
  int long_hold;
  int rx_wait;
  int errors;
  int words_sent;
  int cycles;

  conv3x3_pixel_filter DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Size register as the block uses it: zero reads as one, clamp at the max
  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  // Weighted sum of one channel, fraction dropped, clipped to 0..255
  function automatic logic [CH_W-1:0] channel_sum(tap_grid_t taps, int ch);
    longint acc;
    coef_t  wgt;
    acc = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        wgt = sh_coef[i][COEF_W*j +: COEF_W];
        acc += longint'(taps[i][j][CH_W*ch +: CH_W]) * longint'(wgt);
      end
    if (acc < 0) return '0;
    acc = acc >>> COEF_FRAC_BITS;
    return (acc > 255) ? 8'hFF : acc[7:0];
  endfunction

  // Advance the window by one accepted word; queue the result it releases
  function automatic void conv_accept_pixel(logic drain, pix_t px);
    int unsigned  w, h, r, c, col, orow, ocol;
    pix_t         top, mid, bot;
    tap_grid_t    taps;
    logic         emit;
    filt_result_t res;
    w    = eff_dim(sh_width, MAX_WIDTH);
    h    = eff_dim(sh_height, MAX_HEIGHT);
    r    = pos_row;
    c    = pos_col;
    col  = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
    top  = (r >= 2) ? row_prev2[col] : '0;
    mid  = (r >= 1) ? row_prev[col] : '0;
    bot  = drain ? '0 : px;
    emit = 1'b0;
    orow = 0;
    ocol = 0;
    taps = '0;

    // first word of a row closes the last pixel of the row two above
    if (c == 0 && r >= 2 && r - 2 < h) begin
      emit = 1'b1;
      orow = r - 2;
      ocol = w - 1;
      for (int i = 0; i < 3; i++) begin
        taps[i][0] = win_px[i][1];
        taps[i][1] = win_px[i][2];
        taps[i][2] = '0;
      end
    end

    for (int i = 0; i < 3; i++) begin
      win_px[i][0] = win_px[i][1];
      win_px[i][1] = win_px[i][2];
    end
    win_px[0][2]   = top;
    win_px[1][2]   = mid;
    win_px[2][2]   = bot;
    row_prev2[col] = mid;
    row_prev[col]  = bot;

    if (c >= 1 && r >= 1 && r - 1 < h) begin
      emit = 1'b1;
      orow = r - 1;
      ocol = c - 1;
      taps = win_px;
    end

    if (c + 1 >= w) begin
      pos_col = 0;
      pos_row = (r >= h + 1) ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
    end

    if (!emit) return;

    // taps outside the frame read as zero
    for (int j = 0; j < 3; j++) begin
      if (orow == 0) taps[0][j] = '0;
      if (orow + 1 >= h) taps[2][j] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      if (ocol == 0) taps[i][0] = '0;
      if (ocol + 1 >= w) taps[i][2] = '0;
    end

    res.out0 = channel_sum(taps, 0);
    res.out1 = sh_rgb ? channel_sum(taps, 1) : '0;
    res.out2 = sh_rgb ? channel_sum(taps, 2) : '0;
    res.eof  = (orow + 1 >= h) && (ocol + 1 >= w);
    pending_results.push_back(res);
    if (res.eof) begin
      pos_row = 0;
      pos_col = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int draw_gap(bit burst);
    if (burst || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return pix_t'($urandom);
    endcase
  endfunction

  // Three Q4.12 weights: mostly moderate, some full range, some at the extremes
  function automatic logic [COEF_ROW_W-1:0] rand_kernel_row();
    logic [COEF_ROW_W-1:0] row;
    logic [COEF_W-1:0]     wv;
    for (int j = 0; j < 3; j++) begin
      case ($urandom_range(0, 5))
        0: wv = COEF_W'($urandom);
        1: begin
          case ($urandom_range(0, 3))
            0:       wv = 16'h7FFF;
            1:       wv = 16'h8000;
            2:       wv = 16'hFFFF;
            default: wv = 16'h0000;
          endcase
        end
        default: wv = COEF_W'($urandom_range(0, 3072)) - 16'd512;
      endcase
      row[COEF_W*j +: COEF_W] = wv;
    end
    return row;
  endfunction

  function automatic void queue_write(cfg_reg_e idx, logic [COEF_ROW_W-1:0] value);
    reg_write_t wr;
    wr.idx   = idx;
    wr.value = value;
    reg_writes.push_back(wr);
  endfunction

  function automatic void pick_kernel();
    queue_write(REG_COLOR_MODE, COEF_ROW_W'($urandom_range(0, 1)));
    queue_write(REG_COEF_TOP, rand_kernel_row());
    queue_write(REG_COEF_MID, rand_kernel_row());
    queue_write(REG_COEF_BOT, rand_kernel_row());
  endfunction

  // Offer one word, wait for it to be taken, then predict
  task automatic send_pixel(logic drain, pix_t px);
    int gap;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    s_tuser  <= drain;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    conv_accept_pixel(drain, px);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Register writes go in only once the pipeline has drained
  task automatic apply_settings();
    wait_results();
    repeat (8) @(negedge clk);
    foreach (reg_writes[k]) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_writes[k].idx;
      cfg_data  <= reg_writes[k].value;
      case (reg_writes[k].idx)
        REG_FRAME_WIDTH:  sh_width   = reg_writes[k].value[DIM_W-1:0];
        REG_FRAME_HEIGHT: sh_height  = reg_writes[k].value[DIM_W-1:0];
        REG_COLOR_MODE:   sh_rgb     = reg_writes[k].value[0];
        REG_COEF_TOP:     sh_coef[0] = reg_writes[k].value;
        REG_COEF_MID:     sh_coef[1] = reg_writes[k].value;
        REG_COEF_BOT:     sh_coef[2] = reg_writes[k].value;
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    reg_writes.delete();
  endtask

  // Feed trailing words (mostly drains, some stray pixels) until the frame closes
  task automatic flush_frame();
    while (pos_row != 0 || pos_col != 0)
      send_pixel($urandom_range(0, 3) != 0, rand_pixel());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset kernel and grey mode; checkerboard, a drain inside, a pixel past the end
  task automatic test_default_kernel();
    pix_t px;
    queue_write(REG_FRAME_WIDTH, 3);
    queue_write(REG_FRAME_HEIGHT, 3);
    apply_settings();
    for (int k = 0; k < 9; k++) begin
      px = {16'($urandom), (k % 2 == 0) ? 8'hFF : 8'h00};
      if (k == 4) send_pixel(1'b1, '1);
      else send_pixel(1'b0, px);
    end
    send_pixel(1'b0, '1);
    flush_frame();
  endtask

  // RGB with saturating, most negative and all -1 weights
  task automatic test_rgb_extremes();
    queue_write(REG_FRAME_WIDTH, 3);
    queue_write(REG_FRAME_HEIGHT, 2);
    queue_write(REG_COLOR_MODE, 1);
    queue_write(REG_COEF_TOP, 48'h7FFF_7FFF_7FFF);
    queue_write(REG_COEF_MID, 48'h8000_1000_8000);
    queue_write(REG_COEF_BOT, 48'hFFFF_FFFF_FFFF);
    apply_settings();
    for (int k = 0; k < 6; k++)
      send_pixel(1'b0, (k % 2 == 0) ? pix_t'('1) : pix_t'($urandom));
    flush_frame();
  endtask

  // Size registers at zero and one, single rows and single columns
  task automatic test_frame_extremes();
    int wl [6] = '{0, 1, 5, 2, 9, 1};
    int hl [6] = '{0, 4, 1, 2, 1, 9};
    int n;
    for (int k = 0; k < 6; k++) begin
      queue_write(REG_FRAME_WIDTH, COEF_ROW_W'(wl[k]));
      queue_write(REG_FRAME_HEIGHT, COEF_ROW_W'(hl[k]));
      pick_kernel();
      apply_settings();
      n = eff_dim(DIM_W'(wl[k]), MAX_WIDTH) * eff_dim(DIM_W'(hl[k]), MAX_HEIGHT);
      repeat (n) send_pixel($urandom_range(0, 15) == 0, rand_pixel());
      flush_frame();
    end
  endtask

  // Long output stall with a steady sender, then a pause until drained
  task automatic test_backpressure();
    queue_write(REG_FRAME_WIDTH, 6);
    queue_write(REG_FRAME_HEIGHT, 5);
    pick_kernel();
    apply_settings();
    tx_burst  = 1'b1;
    long_hold = 300;
    for (int k = 0; k < 20; k++) send_pixel(1'b0, rand_pixel());
    wait_results();
    // no idling on either side for the rest of the frame's pixels
    rx_burst = 1'b1;
    for (int k = 20; k < 30; k++) send_pixel(1'b0, rand_pixel());
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    flush_frame();
  endtask

  // Random sizes and kernels; mostly whole frames, some ragged runs of words
  task automatic test_random_streams();
    int   start;
    int   w;
    int   h;
    int   n;
    int   frame;
    bit   noisy;
    logic drain;
    start = words_sent;
    while (words_sent - start < 720) begin
      case ($urandom_range(0, 9))
        0:       w = 0;
        1:       w = $urandom_range(1, 3);
        2:       w = $urandom_range(13, 40);
        default: w = $urandom_range(2, 12);
      endcase
      h = (w > 12) ? $urandom_range(1, 3) : $urandom_range(0, 7);
      queue_write(REG_FRAME_WIDTH, COEF_ROW_W'(w));
      queue_write(REG_FRAME_HEIGHT, COEF_ROW_W'(h));
      pick_kernel();
      apply_settings();
      tx_burst = ($urandom_range(0, 4) == 0);
      rx_burst = ($urandom_range(0, 4) == 0);
      frame = eff_dim(DIM_W'(w), MAX_WIDTH) * eff_dim(DIM_W'(h), MAX_HEIGHT);
      noisy = ($urandom_range(0, 3) == 0);
      n = noisy ? $urandom_range(1, 2 * frame + 8) : frame;
      for (int k = 0; k < n; k++) begin
        drain = noisy ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 15) == 0);
        send_pixel(drain, rand_pixel());
      end
      flush_frame();
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Ready control: long hold first, then the per-word wait
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold > 0) begin
        m_tready <= 1'b0;
        long_hold--;
      end else if (rx_wait > 0) begin
        m_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_tready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  task automatic report_mismatch(string field, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
  endtask

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin : result_check
    filt_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, got data %h last %b",
                 $time, m_tdata, m_tlast);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[7:0] !== want.out0) report_mismatch("out0", want.out0, m_tdata[7:0]);
        if (m_tdata[15:8] !== want.out1) report_mismatch("out1", want.out1, m_tdata[15:8]);
        if (m_tdata[23:16] !== want.out2) report_mismatch("out2", want.out2, m_tdata[23:16]);
        if (m_tlast !== want.eof) report_mismatch("end_of_frame", want.eof, m_tlast);
      end
      rx_wait = draw_gap(rx_burst);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data  = '0;

    // predictor starts from the reset defaults
    sh_width   = WIDTH_RST;
    sh_height  = HEIGHT_RST;
    sh_rgb     = 1'b0;
    sh_coef[0] = COEF_TOP_RST;
    sh_coef[1] = COEF_MID_RST;
    sh_coef[2] = COEF_BOT_RST;
    win_px     = '0;
    pos_col    = 0;
    pos_row    = 0;
    foreach (row_prev[k]) begin
      row_prev[k]  = '0;
      row_prev2[k] = '0;
    end

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_kernel();
    test_rgb_extremes();
    test_frame_extremes();
    test_backpressure();
    test_random_streams();

    wait_results();
    repeat (20) @(negedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/c3x3_pkg.sv
hw/rtl/c3x3_ram.sv
hw/rtl/c3x3_cell.sv
hw/rtl/conv3x3_pixel_filter.sv
hw/rtl/c3x3_checker.sv
sim/tb.sv
